// File: src/mu8_pkg.sv
// ----------------------------------------------------------------------------
// mu8_pkg
// shared types and constants for the modified-utf-8 to utf-16 decoder
// ----------------------------------------------------------------------------
package mu8_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_CONT,
    KIND_BAD
  } byte_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEAD  = 2'd1,
    STATUS_BAD_CONT  = 2'd2,
    STATUS_PARTIAL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    byte_kind_t kind;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic        string_end;
  } result_t;

endpackage

// File: src/mutf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// mutf8_to_utf16_decoder_unit
// java modified-utf-8 byte stream to utf-16 code unit decoder
// ----------------------------------------------------------------------------
// slave side takes one encoded byte per beat in s_tdata, with s_tlast on the
// final byte of a string. master side gives one utf-16 code unit per beat in
// m_tdata, the status code in m_tuser and the end-of-string flag in m_tlast.
// a 1-byte character gives its result from that byte, 2- and 3-byte
// characters from their last continuation byte; lead and middle bytes give
// no beat. on an error one beat with a nonzero status and zero data is sent,
// then bytes are dropped through the final byte of the string.
// a byte is written into the queue, then decoded into the output register.
// throughput: one byte per cycle unless a held result stalls, set by the
// combinational decode and the two-entry queue after the classifier.
// when m_tready is low the result holds; the queue keeps taking bytes until
// its two entries are full, then s_tready drops.
// synchronous reset clears the queue, the output valid flag and the sequence
// state; the first byte after reset starts a new character.
// ----------------------------------------------------------------------------
module mutf8_to_utf16_decoder_unit
  import mu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // code_unit[15:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  byte_item_t in_item;
  byte_item_t head_item;
  logic       head_valid;
  logic       head_ready;
  result_t    result;

  mu8_classify u_classify (
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .item      (in_item)
  );

  mu8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_item  (in_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  mu8_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (head_valid),
    .item_ready (head_ready),
    .item       (head_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = result.code_unit;
  assign m_tuser = result.status;
  assign m_tlast = result.string_end;

endmodule

// File: src/mu8_classify.sv
// ----------------------------------------------------------------------------
// mu8_classify
// front end: tags each incoming byte with its utf-8 role
// ----------------------------------------------------------------------------
module mu8_classify
  import mu8_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output byte_item_t item
);

  byte_kind_t kind;

  always_comb begin
    unique casez (data_byte)
      8'b0???????: kind = KIND_ASCII;
      8'b10??????: kind = KIND_CONT;
      8'b110?????: kind = KIND_LEAD2;
      8'b1110????: kind = KIND_LEAD3;
      default:     kind = KIND_BAD;
    endcase
  end

  assign item.data_byte = data_byte;
  assign item.last_byte = last_byte;
  assign item.kind      = kind;

endmodule

// File: src/mu8_queue.sv
// ----------------------------------------------------------------------------
// mu8_queue
// short fifo between classifier and decoder
// ----------------------------------------------------------------------------
module mu8_queue
  import mu8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  byte_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output byte_item_t pop_item
);

  byte_item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/mu8_decode.sv
// ----------------------------------------------------------------------------
// mu8_decode
// back end: sequence state, error handling and output register
// ----------------------------------------------------------------------------
module mu8_decode
  import mu8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  byte_item_t item,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_result
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [9:0]  partial_bits, partial_bits_next;
  logic        drop_to_end, drop_to_end_next;
  logic        emit;
  result_t     result;
  logic        advance;
  logic        fail;
  status_t     fail_status;

  assign advance    = !out_valid || out_ready;
  assign item_ready = advance;

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_bits_next  = partial_bits;
    drop_to_end_next   = drop_to_end;
    emit               = 1'b0;
    fail               = 1'b0;
    fail_status        = STATUS_OK;
    result.code_unit   = '0;
    result.status      = STATUS_OK;
    result.string_end  = item.last_byte;
    if (drop_to_end) begin
      if (item.last_byte) begin
        drop_to_end_next = 1'b0;
      end
    end else if (bytes_pending == 2'd0) begin
      unique case (item.kind)
        KIND_ASCII: begin
          emit             = 1'b1;
          result.code_unit = {8'd0, item.data_byte};
        end
        KIND_LEAD2: begin
          if (item.last_byte) begin
            fail        = 1'b1;
            fail_status = STATUS_PARTIAL;
          end else begin
            bytes_pending_next = 2'd1;
            partial_bits_next  = {5'd0, item.data_byte[4:0]};
          end
        end
        KIND_LEAD3: begin
          if (item.last_byte) begin
            fail        = 1'b1;
            fail_status = STATUS_PARTIAL;
          end else begin
            bytes_pending_next = 2'd2;
            partial_bits_next  = {6'd0, item.data_byte[3:0]};
          end
        end
        default: begin
          fail        = 1'b1;
          fail_status = STATUS_BAD_LEAD;
        end
      endcase
    end else if (item.kind != KIND_CONT) begin
      fail        = 1'b1;
      fail_status = (item.last_byte && bytes_pending > 2'd1) ? STATUS_PARTIAL
                                                             : STATUS_BAD_CONT;
    end else if (bytes_pending > 2'd1) begin
      if (item.last_byte) begin
        fail        = 1'b1;
        fail_status = STATUS_PARTIAL;
      end else begin
        partial_bits_next  = {partial_bits[3:0], item.data_byte[5:0]};
        bytes_pending_next = 2'd1;
      end
    end else begin
      emit               = 1'b1;
      result.code_unit   = {partial_bits, item.data_byte[5:0]};
      bytes_pending_next = 2'd0;
      partial_bits_next  = '0;
    end
    if (fail) begin
      emit               = 1'b1;
      result.code_unit   = '0;
      result.status      = fail_status;
      bytes_pending_next = 2'd0;
      partial_bits_next  = '0;
      drop_to_end_next   = !item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_bits  <= '0;
      drop_to_end   <= 1'b0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && emit;
      if (item_valid) begin
        bytes_pending <= bytes_pending_next;
        partial_bits  <= partial_bits_next;
        drop_to_end   <= drop_to_end_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && emit) begin
      out_result <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst) bytes_pending != 2'd3)
    else $error("bytes_pending out of range");

  assert property (@(posedge clk) disable iff (rst)
    drop_to_end |-> (bytes_pending == 2'd0 && partial_bits == '0))
    else $error("open character while dropping");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.status != STATUS_OK) |-> out_result.code_unit == '0)
    else $error("error result with nonzero code unit");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
    else $error("stalled result changed");

endmodule

// File: tb/mutf8_decode_checker.sv
// ----------------------------------------------------------------------------
// mutf8_decode_checker
// watches both streams of the modified-utf-8 decoder and checks its results
// ----------------------------------------------------------------------------
// every byte beat taken on the slave side is run through a local decoder
// that keeps its own sequence state and queues the code unit or error it
// should give. every beat on the master side is compared with the oldest
// queued unit, field by field. the counts go back to the testbench top.
// ----------------------------------------------------------------------------
module mutf8_decode_checker
  import mu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // code_unit[15:0]
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        m_tlast,
  output int          mismatches,
  output int          units_waiting,
  output int          units_checked,
  output int          error_units
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0] conts_owed;
  logic [9:0] gathered_bits;
  logic       skipping;
  result_t    expected_units[$];

  task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
    $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
    mismatches++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic        give;
    logic        err;
    status_t     st;
    logic [15:0] unit;
    result_t     res;
    give = 1'b0;
    err  = 1'b0;
    st   = STATUS_OK;
    unit = '0;
    if (skipping) begin
      if (fin) skipping = 1'b0;
    end else if (conts_owed == 2'd0) begin
      if (!b[7]) begin
        give = 1'b1;
        unit = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
        if (fin) begin
          err = 1'b1;
          st  = STATUS_PARTIAL;
        end else begin
          conts_owed    = 2'd1;
          gathered_bits = {5'b0, b[4:0]};
        end
      end else if (b[7:4] == 4'b1110) begin
        if (fin) begin
          err = 1'b1;
          st  = STATUS_PARTIAL;
        end else begin
          conts_owed    = 2'd2;
          gathered_bits = {6'b0, b[3:0]};
        end
      end else begin
        err = 1'b1;
        st  = STATUS_BAD_LEAD;
      end
    end else if (b[7:6] != 2'b10) begin
      err = 1'b1;
      st  = (fin && conts_owed > 2'd1) ? STATUS_PARTIAL : STATUS_BAD_CONT;
    end else if (conts_owed > 2'd1) begin
      if (fin) begin
        err = 1'b1;
        st  = STATUS_PARTIAL;
      end else begin
        gathered_bits = {gathered_bits[3:0], b[5:0]};
        conts_owed    = 2'd1;
      end
    end else begin
      give          = 1'b1;
      unit          = {gathered_bits, b[5:0]};
      conts_owed    = 2'd0;
      gathered_bits = '0;
    end
    if (err) begin
      conts_owed    = 2'd0;
      gathered_bits = '0;
      skipping      = !fin;
      give          = 1'b1;
      unit          = '0;
    end
    if (give) begin
      res.code_unit  = unit;
      res.status     = st;
      res.string_end = fin;
      expected_units.insert(expected_units.size(), res);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      conts_owed    = 2'd0;
      gathered_bits = '0;
      skipping      = 1'b0;
      expected_units.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_units.size() == 0) begin
          report_mismatch("beat with nothing expected, data", 16'h0, m_tdata);
        end else begin
          want = expected_units.pop_front();
          if (m_tdata !== want.code_unit)
            report_mismatch("code unit", want.code_unit, m_tdata);
          if (m_tuser !== want.status)
            report_mismatch("status", {14'b0, want.status}, {14'b0, m_tuser});
          if (m_tlast !== want.string_end)
            report_mismatch("string end", {15'b0, want.string_end}, {15'b0, m_tlast});
          units_checked++;
          if (want.status != STATUS_OK) error_units++;
        end
      end
    end
    units_waiting = expected_units.size();
  end

endmodule

// File: tb/tb_mutf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_mutf8_to_utf16_decoder_unit
// stimulus and verdict for the modified-utf-8 to utf-16 decoder
// ----------------------------------------------------------------------------
// a directed set of strings hits the code unit extremes, every error status
// and the drop-to-end behavior, then random strings follow: mostly well
// formed with random characters, the rest truncated, corrupted or noise.
// both sides idle at random, apart from one stretch at full rate. a separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_mutf8_to_utf16_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mu8_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int IDLE_PCT    = 21;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  bit          calm = 1'b0;
  int          bytes_sent;
  int          strings_sent;
  int          cycle_count;
  int          mismatches;
  int          units_waiting;
  int          units_checked;
  int          error_units;
  logic [7:0]  str_bytes[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mutf8_to_utf16_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  mutf8_decode_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .units_waiting (units_waiting),
    .units_checked (units_checked),
    .error_units   (error_units)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_mutf8_to_utf16_decoder_unit: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < str_bytes.size(); i++)
      send_beat(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
    strings_sent++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  task automatic add_char(input int kind);
    logic [31:0] r;
    r = $urandom;
    unique case (kind)
      0: begin
        append_byte({1'b0, r[6:0]});
      end
      1: begin
        append_byte({3'b110, r[4:0]});
        append_byte({2'b10, r[10:5]});
      end
      default: begin
        append_byte({4'b1110, r[3:0]});
        append_byte({2'b10, r[9:4]});
        append_byte({2'b10, r[15:10]});
      end
    endcase
  endtask

  task automatic make_random_string();
    int          mode;
    int          n;
    int          pos;
    logic [31:0] r;
    mode = $urandom_range(0, 99);
    if (mode < 93) begin
      n = $urandom_range(1, 10);
      repeat (n) add_char($urandom_range(0, 2));
    end
    r = $urandom;
    if (mode >= 78 && mode < 86) begin
      // cut off inside a character
      if (r[0]) begin
        append_byte({3'b110, r[5:1]});
      end else begin
        append_byte({4'b1110, r[4:1]});
        if (r[8]) append_byte({2'b10, r[14:9]});
      end
    end else if (mode >= 86 && mode < 93) begin
      pos = $urandom_range(0, str_bytes.size() - 1);
      str_bytes[pos] = r[7:0];
    end else if (mode >= 93) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        r = $urandom;
        append_byte(r[7:0]);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    str_bytes = '{8'h7F, 8'h00};
    send_string();
    str_bytes = '{8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    send_string();
    // bad lead bytes, alone and followed by dropped bytes
    str_bytes = '{8'h80};
    send_string();
    str_bytes = '{8'hFF, 8'h41};
    send_string();
    str_bytes = '{8'hF0};
    send_string();
    // bad continuation, mid-string and on the final byte
    str_bytes = '{8'hC3, 8'h41, 8'h55};
    send_string();
    str_bytes = '{8'hC3, 8'h41};
    send_string();
    // string ends inside a character, then a bad continuation with a dropped tail
    str_bytes = '{8'hC3};
    send_string();
    str_bytes = '{8'hE2, 8'h82};
    send_string();
    str_bytes = '{8'hE2, 8'h41};
    send_string();
    str_bytes = '{8'hE2, 8'h82, 8'h00, 8'h80};
    send_string();

    while (bytes_sent < ITEM_TARGET) begin
      calm = (bytes_sent >= 700 && bytes_sent < 1000);
      make_random_string();
      send_string();
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (units_waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d bytes in %0d strings, checked %0d result beats (%0d errors)",
             bytes_sent, strings_sent, units_checked, error_units);
    if (mismatches == 0 && units_waiting == 0) begin
      $display("tb_mutf8_to_utf16_decoder_unit: PASS");
    end else begin
      $display("tb_mutf8_to_utf16_decoder_unit: FAIL");
    end
    $finish;
  end

endmodule

// File: mutf8_to_utf16_decoder_unit.f
src/mu8_pkg.sv
src/mu8_classify.sv
src/mu8_queue.sv
src/mu8_decode.sv
src/mutf8_to_utf16_decoder_unit.sv
tb/mutf8_decode_checker.sv
tb/tb_mutf8_to_utf16_decoder_unit.sv
